FILE: rtl/cemb_pkg.sv
`default_nettype none

package cemb_pkg;

   // Field widths fixed by the interface
   localparam int CMD_W  = 1;
   localparam int KIND_W = 3;
   localparam int CAP_W  = 6;
   localparam int FILL_W = 6;
   localparam int STAT_W = 2;

   // Capacity register value after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

   // Operation codes
   localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
   localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

   // Event kinds
   localparam logic [KIND_W-1:0] KIND_STATE    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_POSITION = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FRAME    = 3'd2;

   // Terminal states carried in the low bits of a state-changed payload
   localparam logic [2:0] STATE_SHUTDOWN = 3'd6;
   localparam logic [2:0] STATE_ERROR    = 3'd7;

   // Push status codes
   localparam logic [STAT_W-1:0] ST_APPENDED  = 2'd0;
   localparam logic [STAT_W-1:0] ST_COALESCED = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STAT_W-1:0] ST_ZERO_CAP  = 2'd3;

   // Controller to datapath
   typedef struct packed {
      logic capture;  // latch the accepted request
      logic commit;   // execute it and load the response register
   } cemb_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_busy; // response register holds a transfer not yet taken
   } cemb_sts_type;

endpackage

`default_nettype wire

FILE: rtl/cemb_ctrl.sv
`default_nettype none

module cemb_ctrl
   import cemb_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire cemb_sts_type sts,
   output cemb_cmd_type      cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Handshake and commands
   assign req_ready   = (state_ff == S_IDLE);
   assign cmd.capture = req_valid && (state_ff == S_IDLE);
   assign cmd.commit  = (state_ff == S_EXEC) && !sts.out_busy;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (!sts.out_busy) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

FILE: rtl/cemb_dp.sv
`default_nettype none

module cemb_dp
   import cemb_pkg::*;
#(
   parameter int QUEUE_DEPTH  = 32,
   parameter int PAYLOAD_BITS = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cemb_cmd_type             cmd,
   output cemb_sts_type                  sts,
   input  wire logic [CMD_W-1:0]         req_cmd,
   input  wire logic [KIND_W-1:0]        req_event_kind,
   input  wire logic [PAYLOAD_BITS-1:0]  req_event_payload,
   input  wire logic                     csr_we,
   input  wire logic [CAP_W-1:0]         csr_wdata,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [STAT_W-1:0]             rsp_push_status,
   output logic                          rsp_pop_valid,
   output logic [KIND_W-1:0]             rsp_pop_kind,
   output logic [PAYLOAD_BITS-1:0]       rsp_pop_payload,
   output logic [FILL_W-1:0]             rsp_fill_level
);

   localparam int IDX_W      = $clog2(QUEUE_DEPTH);
   localparam int SUM_W      = ((IDX_W > FILL_W) ? IDX_W : FILL_W) + 1;
   localparam int DEPTH_CLIP = (QUEUE_DEPTH > 63) ? 63 : QUEUE_DEPTH;

   // Slot storage
   logic [KIND_W-1:0]       slot_kind_ff    [QUEUE_DEPTH];
   logic [PAYLOAD_BITS-1:0] slot_payload_ff [QUEUE_DEPTH];

   // Queue bookkeeping
   logic [CAP_W-1:0]  cap_ff,     cap_in;
   logic [IDX_W-1:0]  head_ff,    head_in;
   logic [FILL_W-1:0] count_ff,   count_in;
   logic              pos_q_ff,   pos_q_in;
   logic [IDX_W-1:0]  pos_slot_ff, pos_slot_in;
   logic              frm_q_ff,   frm_q_in;
   logic [IDX_W-1:0]  frm_slot_ff, frm_slot_in;

   // Latched request
   logic [CMD_W-1:0]        op_ff;
   logic [KIND_W-1:0]       kind_ff;
   logic [PAYLOAD_BITS-1:0] payload_ff;

   // Response register
   logic                    rsp_valid_ff,  rsp_valid_in;
   logic [STAT_W-1:0]       status_ff,     status_in;
   logic                    pop_valid_ff,  pop_valid_in;
   logic [FILL_W-1:0]       fill_ff;
   logic [KIND_W-1:0]       rd_kind_ff;
   logic [PAYLOAD_BITS-1:0] rd_payload_ff;

   // Decision terms
   logic [CAP_W-1:0]  eff_cap;
   logic [CAP_W-1:0]  limit;
   logic [SUM_W-1:0]  tail_sum;
   logic [IDX_W-1:0]  tail;
   logic [IDX_W-1:0]  wr_addr;
   logic              mem_we;
   logic              rd_en;
   logic              terminal;

   assign sts.out_busy = rsp_valid_ff && !rsp_ready;

   // Effective capacity and tail slot
   assign eff_cap  = (cap_ff > CAP_W'(DEPTH_CLIP)) ? CAP_W'(DEPTH_CLIP) : cap_ff;
   assign terminal = (kind_ff == KIND_STATE) &&
                     ((payload_ff[2:0] == STATE_SHUTDOWN) ||
                      (payload_ff[2:0] == STATE_ERROR));
   assign limit    = terminal ? eff_cap : (eff_cap - CAP_W'(1));
   assign tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                     IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);

   // Push / pop decision
   always_comb begin
      cap_in       = csr_we ? csr_wdata : cap_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      pos_q_in     = pos_q_ff;
      pos_slot_in  = pos_slot_ff;
      frm_q_in     = frm_q_ff;
      frm_slot_in  = frm_slot_ff;
      status_in    = ST_APPENDED;
      pop_valid_in = 1'b0;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      wr_addr      = tail;
      if (cmd.commit) begin
         if (op_ff == CMD_PUSH) begin
            priority if (eff_cap == '0) begin
               status_in = ST_ZERO_CAP;
            end else if ((kind_ff == KIND_POSITION) && pos_q_ff) begin
               status_in = ST_COALESCED;
               mem_we    = 1'b1;
               wr_addr   = pos_slot_ff;
            end else if ((kind_ff == KIND_FRAME) && frm_q_ff) begin
               status_in = ST_COALESCED;
               mem_we    = 1'b1;
               wr_addr   = frm_slot_ff;
            end else if (count_ff >= limit) begin
               status_in = ST_FULL;
            end else begin
               mem_we   = 1'b1;
               count_in = count_ff + FILL_W'(1);
               if (kind_ff == KIND_POSITION) begin
                  pos_q_in    = 1'b1;
                  pos_slot_in = tail;
               end
               if (kind_ff == KIND_FRAME) begin
                  frm_q_in    = 1'b1;
                  frm_slot_in = tail;
               end
            end
         end else if (count_ff != '0) begin
            pop_valid_in = 1'b1;
            rd_en        = 1'b1;
            count_in     = count_ff - FILL_W'(1);
            head_in      = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
            if (pos_q_ff && (pos_slot_ff == head_ff)) pos_q_in = 1'b0;
            if (frm_q_ff && (frm_slot_ff == head_ff)) frm_q_in = 1'b0;
         end
      end
   end

   // Response valid: loaded on commit, dropped when taken
   always_comb begin
      priority if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_ready)      rsp_valid_in = 1'b0;
      else                     rsp_valid_in = rsp_valid_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         head_ff      <= '0;
         count_ff     <= '0;
         pos_q_ff     <= 1'b0;
         pos_slot_ff  <= '0;
         frm_q_ff     <= 1'b0;
         frm_slot_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pos_q_ff     <= pos_q_in;
         pos_slot_ff  <= pos_slot_in;
         frm_q_ff     <= frm_q_in;
         frm_slot_ff  <= frm_slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request latch and response fields
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_cmd;
         kind_ff    <= req_event_kind;
         payload_ff <= req_event_payload;
      end
      if (cmd.commit) begin
         status_ff    <= status_in;
         pop_valid_ff <= pop_valid_in;
         fill_ff      <= count_in;
      end
   end

   // Slot memory: one write port, one registered read port at the head
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_kind_ff[wr_addr]    <= kind_ff;
         slot_payload_ff[wr_addr] <= payload_ff;
      end
      if (rd_en) begin
         rd_kind_ff    <= slot_kind_ff[head_ff];
         rd_payload_ff <= slot_payload_ff[head_ff];
      end
   end

   // Outputs; popped fields read as zero unless a pop returned an entry
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_push_status = status_ff;
   assign rsp_pop_valid   = pop_valid_ff;
   assign rsp_pop_kind    = pop_valid_ff ? rd_kind_ff : '0;
   assign rsp_pop_payload = pop_valid_ff ? rd_payload_ff : '0;
   assign rsp_fill_level  = fill_ff;

endmodule

`default_nettype wire

FILE: rtl/coalescing_event_mailbox_unit.sv
// Coalescing event mailbox: a bounded queue of typed events.
// Request channel (req_valid/req_ready): req_cmd selects push or pop;
// req_event_kind and req_event_payload carry the event for a push.
// Response channel (rsp_valid/rsp_ready): one transfer per request with
// push status, popped entry (zero when none) and fill level after the op.
// Position and frame-presented pushes overwrite their queued entry in place;
// ordinary events use at most capacity minus one slots, the last one is
// kept for Shutdown/Error state changes.
// Config: csr_we with csr_wdata writes the capacity; write only while idle.
// An accepted request is latched, then executed in the execute state, which
// loads the response register; no new request is accepted until then, set by
// the accept/execute sequence of the controller around the slot memory.
// The response register decouples the sides: when the receiver stalls, the
// next request is still accepted and waits in the execute state until the
// held response is taken.
// Reset (synchronous): queue empty, capacity 32, no response pending; slot
// contents are not cleared.
`default_nettype none

module coalescing_event_mailbox_unit
   import cemb_pkg::*;
#(
   parameter int QUEUE_DEPTH  = 32,
   parameter int PAYLOAD_BITS = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [CMD_W-1:0]         req_cmd,
   input  wire logic [KIND_W-1:0]        req_event_kind,
   input  wire logic [PAYLOAD_BITS-1:0]  req_event_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [STAT_W-1:0]             rsp_push_status,
   output logic                          rsp_pop_valid,
   output logic [KIND_W-1:0]             rsp_pop_kind,
   output logic [PAYLOAD_BITS-1:0]       rsp_pop_payload,
   output logic [FILL_W-1:0]             rsp_fill_level,
   input  wire logic                     csr_we,
   input  wire logic [CAP_W-1:0]         csr_wdata
);

   cemb_cmd_type cmd;
   cemb_sts_type sts;

   // Sequencer
   cemb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Queue state, slot memory and response register
   cemb_dp #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_cmd           (req_cmd),
      .req_event_kind    (req_event_kind),
      .req_event_payload (req_event_payload),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_push_status   (rsp_push_status),
      .rsp_pop_valid     (rsp_pop_valid),
      .rsp_pop_kind      (rsp_pop_kind),
      .rsp_pop_payload   (rsp_pop_payload),
      .rsp_fill_level    (rsp_fill_level)
   );

endmodule

`default_nettype wire
